### design/nfa_string_acceptor_macros.svh
// Assertion macros shared by the NFA acceptor RTL.
// Include by bare file name; no other dependencies.
`ifndef NFA_STRING_ACCEPTOR_MACROS_SVH
`define NFA_STRING_ACCEPTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nfa_pkg.sv
// Shared types and constants of the NFA acceptor.
// Used by nfa_ctrl, nfa_dpath and nfa_string_acceptor; no dependencies.
`default_nettype none

package nfa_pkg;

  localparam int unsigned CmdW        = 2;
  localparam int unsigned StateFieldW = 4;
  localparam int unsigned SymFieldW   = 8;
  localparam int unsigned StateCountW = 5;
  localparam int unsigned IndexW      = 16;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 24;

  localparam logic [IndexW-1:0] IndexMax = 16'hFFFF;

  localparam logic [CmdW-1:0] CmdClear = 2'd0;
  localparam logic [CmdW-1:0] CmdAdd   = 2'd1;
  localparam logic [CmdW-1:0] CmdChar  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_write;
    logic add_read;
    logic add_write;
    logic scan_step;
    logic finish;
  } nfa_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic add_ok;
    logic scan_last;
    logic rejected;
    logic last;
    logic out_free;
  } nfa_sts_t;

endpackage

`default_nettype wire

### design/nfa_string_acceptor.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tuser=command, tdata, tlast=last
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata={stop_index, accepted}
// cfg       in   cfg_we_i                        cfg_wdata_i=state_count
//
// A text character makes one table read per state (n = effective state count) from
// the single-port transition memory, then a drain step and an update step.
// A character after a rejected one skips the table reads; an add is a read-modify-write.
// Reset and every clear item sweep all MAX_STATES << SYMBOL_BITS words of the memory
// (4096 by default), one word a cycle, with no item accepted. Result waits in its own
// register; the block stalls only when a word ends while that register is still full.
// Top level of the NFA acceptor; depends on nfa_pkg, nfa_ctrl, nfa_dpath and the macros.
`default_nettype none
`include "nfa_string_acceptor_macros.svh"

module nfa_string_acceptor #(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [nfa_pkg::StateCountW-1:0]     cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [3:0] from_state, [11:4] symbol, [15:12] to_state
  input  wire logic [nfa_pkg::InDataW-1:0]         s_axis_tdata_i,
  input  wire logic                                s_axis_tlast_i,
  // [1:0] command
  input  wire logic [nfa_pkg::CmdW-1:0]            s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [0] accepted, [16:1] stop_index, [23:17] zero
  output logic [nfa_pkg::OutDataW-1:0]             m_axis_tdata_o
);

  nfa_pkg::nfa_ctl_t ctl;
  nfa_pkg::nfa_sts_t sts;

  logic                       accepted;
  logic [nfa_pkg::IndexW-1:0] stop_index;

  nfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .ctl_o      (ctl)
  );

  nfa_dpath #(
    .MAX_STATES  (MAX_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .from_state_i (s_axis_tdata_i[3:0]),
    .symbol_i     (s_axis_tdata_i[11:4]),
    .to_state_i   (s_axis_tdata_i[15:12]),
    .last_i       (s_axis_tlast_i),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .accepted_o   (accepted),
    .stop_index_o (stop_index)
  );

  assign m_axis_tdata_o = {7'b0, stop_index, accepted};

  // unknown commands are dropped and keep ready high
  `NFA_ASSERT_NXT(a_ready_drops_after_item, clk_i, rst_ni,
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == nfa_pkg::CmdClear ||
      s_axis_tuser_i == nfa_pkg::CmdAdd || s_axis_tuser_i == nfa_pkg::CmdChar),
    !s_axis_tready_o, "ready held after an accepted item")
  `NFA_ASSERT_IMP(a_no_item_during_sweep, clk_i, rst_ni,
    ctl.clr_write, !s_axis_tready_o, "item taken during table sweep")
  `NFA_ASSERT_IMP(a_result_from_finish, clk_i, rst_ni,
    $rose(m_axis_tvalid_o), $past(ctl.finish) && $past(sts.last),
    "result raised without a finished last character")
  `NFA_ASSERT_IMP(a_finish_has_room, clk_i, rst_ni,
    ctl.finish && sts.last, !m_axis_tvalid_o || m_axis_tready_i,
    "result overwritten before it was taken")

endmodule

`default_nettype wire

### design/nfa_ctrl.sv
// Sequencer of the NFA acceptor: table sweep, add, scan and finish steps.
// Depends on nfa_pkg.
`default_nettype none

module nfa_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [nfa_pkg::CmdW-1:0]  in_cmd_i,
  input  wire nfa_pkg::nfa_sts_t         sts_i,
  output logic                           in_ready_o,
  output nfa_pkg::nfa_ctl_t              ctl_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StAddRd,
    StAddWr,
    StScan,
    StDrain,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      StClear: begin
        ctl_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i && ready_q) begin
          ctl_o.capture = 1'b1;
          unique case (in_cmd_i)
            nfa_pkg::CmdClear: state_d = StClear;
            nfa_pkg::CmdAdd:   state_d = StAddRd;
            nfa_pkg::CmdChar:  state_d = sts_i.rejected ? StFinish : StScan;
            default:           state_d = StIdle;
          endcase
        end
      end
      StAddRd: begin
        // drop adds with out-of-range fields
        if (sts_i.add_ok) begin
          ctl_o.add_read = 1'b1;
          state_d        = StAddWr;
        end else begin
          state_d = StIdle;
        end
      end
      StAddWr: begin
        ctl_o.add_write = 1'b1;
        state_d         = StIdle;
      end
      StScan: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        // hold while a previous result still occupies the output register
        if (!sts_i.last || sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == StIdle);
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

### design/nfa_dpath.sv
// Datapath of the NFA acceptor: transition memory, active set, index and
// result register. Depends on nfa_pkg; steered by nfa_ctrl.
`default_nettype none

module nfa_dpath #(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [nfa_pkg::StateCountW-1:0]     cfg_wdata_i,
  input  wire logic [nfa_pkg::StateFieldW-1:0]     from_state_i,
  input  wire logic [nfa_pkg::SymFieldW-1:0]       symbol_i,
  input  wire logic [nfa_pkg::StateFieldW-1:0]     to_state_i,
  input  wire logic                                last_i,
  input  wire nfa_pkg::nfa_ctl_t                   ctl_i,
  output nfa_pkg::nfa_sts_t                        sts_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic                                     accepted_o,
  output logic [nfa_pkg::IndexW-1:0]               stop_index_o
);

  localparam int unsigned SW       = $clog2(MAX_STATES);
  localparam int unsigned NW       = $clog2(MAX_STATES + 1);
  localparam int unsigned AW       = SW + SYMBOL_BITS;
  localparam int unsigned Depth    = MAX_STATES << SYMBOL_BITS;
  localparam int unsigned SymCount = 1 << SYMBOL_BITS;

  // item registers
  logic [nfa_pkg::StateFieldW-1:0] from_q, to_q;
  logic [nfa_pkg::SymFieldW-1:0]   sym_q;
  logic                            last_q;

  logic [nfa_pkg::StateCountW-1:0] state_count_q;

  logic [MAX_STATES-1:0] tbl_mem [Depth];
  logic [MAX_STATES-1:0] rd_data_q;
  logic [AW-1:0]         mem_addr;
  logic                  mem_we, mem_re;
  logic [MAX_STATES-1:0] mem_wdata;

  logic [AW-1:0]         clr_cnt_q;
  logic [SW-1:0]         scan_q;
  logic                  pend_q;
  logic [MAX_STATES-1:0] next_q;
  logic [MAX_STATES-1:0] active_q;
  logic [nfa_pkg::IndexW-1:0] idx_q;
  logic                  rej_q;

  logic                       out_valid_q, out_acc_q;
  logic [nfa_pkg::IndexW-1:0] out_idx_q;

  logic [NW-1:0]         n_eff;
  logic [SW-1:0]         acc_state;
  logic [MAX_STATES-1:0] live;
  logic                  sym_ok, add_ok, clr_last;

  logic [MAX_STATES-1:0]      new_act;
  logic                       new_rej;
  logic [nfa_pkg::IndexW-1:0] new_idx;
  logic                       new_acc;

  always_comb begin
    if (state_count_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(state_count_q) > MAX_STATES) begin
      n_eff = NW'(MAX_STATES);
    end else begin
      n_eff = NW'(state_count_q);
    end
  end

  assign acc_state = SW'(n_eff - NW'(1));

  always_comb begin
    for (int i = 0; i < MAX_STATES; i++) begin
      live[i] = (i < 32'(n_eff));
    end
  end

  assign sym_ok   = (32'(sym_q) < SymCount);
  assign add_ok   = sym_ok && (32'(from_q) < MAX_STATES) && (32'(to_q) < MAX_STATES);
  assign clr_last = (clr_cnt_q == AW'(Depth - 1));

  // single port: sweep, add or scan address
  always_comb begin
    mem_addr  = {scan_q, sym_q[SYMBOL_BITS-1:0]};
    mem_wdata = rd_data_q | (MAX_STATES'(1) << to_q);
    if (ctl_i.clr_write) begin
      mem_addr  = clr_cnt_q;
      mem_wdata = '0;
    end else if (ctl_i.add_read || ctl_i.add_write) begin
      mem_addr = {SW'(from_q), sym_q[SYMBOL_BITS-1:0]};
    end
  end

  assign mem_we = ctl_i.clr_write || ctl_i.add_write;
  assign mem_re = ctl_i.add_read || ctl_i.scan_step;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= tbl_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      from_q <= from_state_i;
      sym_q  <= symbol_i;
      to_q   <= to_state_i;
      last_q <= last_i;
    end
  end

  // end-of-character update
  always_comb begin
    new_act = active_q;
    new_rej = rej_q;
    new_idx = idx_q;
    if (!rej_q) begin
      new_act = next_q & live;
      new_rej = (new_act == '0);
      if (!new_rej && (idx_q != nfa_pkg::IndexMax)) begin
        new_idx = idx_q + nfa_pkg::IndexW'(1);
      end
    end
    new_acc = !new_rej && new_act[acc_state];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= nfa_pkg::StateCountW'(1);
      clr_cnt_q     <= '0;
      scan_q        <= '0;
      pend_q        <= 1'b0;
      next_q        <= '0;
      active_q      <= MAX_STATES'(1);
      idx_q         <= '0;
      rej_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        state_count_q <= cfg_wdata_i;
      end
      if (ctl_i.clr_write) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
      end
      // a read issued now lands in rd_data_q; fold it in next cycle
      pend_q <= ctl_i.scan_step && active_q[scan_q] && sym_ok;
      if (ctl_i.capture) begin
        scan_q <= '0;
        next_q <= '0;
      end else begin
        if (ctl_i.scan_step) begin
          scan_q <= scan_q + SW'(1);
        end
        if (pend_q) begin
          next_q <= next_q | rd_data_q;
        end
      end
      if (ctl_i.finish) begin
        if (last_q) begin
          active_q <= MAX_STATES'(1);
          idx_q    <= '0;
          rej_q    <= 1'b0;
        end else begin
          active_q <= new_act;
          idx_q    <= new_idx;
          rej_q    <= new_rej;
        end
      end
      if (ctl_i.finish && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish && last_q) begin
      out_acc_q <= new_acc;
      out_idx_q <= idx_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = clr_last;
    sts_o.add_ok    = add_ok;
    sts_o.scan_last = (scan_q == acc_state);
    sts_o.rejected  = rej_q;
    sts_o.last      = last_q;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign stop_index_o = out_idx_q;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking bench for nfa_string_acceptor: loads random automata, feeds words
// through the stream port and checks every verdict against a built-in predictor.
// Depends on nfa_pkg and the nfa_string_acceptor RTL only.
module tb;
  import nfa_pkg::*;

  localparam logic [CmdW-1:0] CmdNone = 2'd3;
  localparam int unsigned StateLimit = 16;
  localparam int unsigned SymBits = 8;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned SweepWait = 4200;
  localparam int unsigned DrainWait = 40;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic              accepted;
    logic [IndexW-1:0] stop_index;
  } verdict_t;

  // Predicts word verdicts from the accepted items and checks the results.
  class verdict_board;
    logic [StateLimit-1:0] targets [StateLimit << SymBits];
    logic [StateLimit-1:0] active;
    logic [IndexW-1:0]     position;
    bit                    rejected_word;
    logic [StateCountW-1:0] count_reg;
    verdict_t              pending_verdicts[$];
    int unsigned           errors;
    int unsigned           verdicts;
    int unsigned           accepts;

    function new();
      wipe_table();
      count_reg = 1;
      restart_word();
      errors = 0;
      verdicts = 0;
      accepts = 0;
    endfunction

    function void wipe_table();
      foreach (targets[i]) targets[i] = '0;
    endfunction

    function void restart_word();
      active = 1;
      position = '0;
      rejected_word = 0;
    endfunction

    function int unsigned states_used();
      if (count_reg == 0) return 1;
      if (count_reg > StateLimit) return StateLimit;
      return count_reg;
    endfunction

    function void set_count(logic [StateCountW-1:0] value);
      count_reg = value;
    endfunction

    function void take_item(logic [CmdW-1:0] cmd, logic [InDataW-1:0] data, logic last);
      logic [3:0]            from_state;
      logic [7:0]            sym;
      logic [3:0]            to_state;
      logic [StateLimit-1:0] next_set;
      logic [IndexW-1:0]     here;
      int unsigned           n;
      verdict_t              v;
      from_state = data[3:0];
      sym = data[11:4];
      to_state = data[15:12];
      case (cmd)
        CmdClear: wipe_table();
        CmdAdd: targets[{from_state, sym}] |= 16'(1) << to_state;
        CmdChar: begin
          n = states_used();
          here = position;
          if (!rejected_word) begin
            next_set = '0;
            for (int s = 0; s < n; s++)
              if (active[s]) next_set |= targets[(s << SymBits) | sym];
            // drop targets beyond the states in use
            next_set &= 16'hFFFF >> (StateLimit - n);
            active = next_set;
            if (next_set == 0) rejected_word = 1;
            else if (position != IndexMax) position++;
          end
          if (last) begin
            v.accepted = !rejected_word && active[n-1];
            v.stop_index = here;
            pending_verdicts.push_back(v);
            restart_word();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(logic [OutDataW-1:0] data);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("result with no verdict pending: tdata 0x%06h", data);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      verdicts++;
      if (v.accepted) accepts++;
      if (data[0] !== v.accepted) begin
        $error("accepted: expected %0d, actual %0d", v.accepted, data[0]);
        errors++;
      end
      if (data[16:1] !== v.stop_index) begin
        $error("stop_index: expected %0d, actual %0d", v.stop_index, data[16:1]);
        errors++;
      end
      if (data[23:17] !== 7'd0) begin
        $error("pad: expected 0, actual 0x%0h", data[23:17]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [StateCountW-1:0] cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [InDataW-1:0]     s_tdata;
  logic                   s_tlast;
  logic [CmdW-1:0]        s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OutDataW-1:0]    m_tdata;

  verdict_board board = new();
  bit           calm;
  int unsigned  idle_pct;
  int unsigned  stall_left;
  bit           sweep_pending;
  int unsigned  fed;
  int unsigned  settings;
  longint unsigned cycles;

  nfa_string_acceptor u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: idle_pct <= 0;
        1: idle_pct <= 10;
        2: idle_pct <= 30;
        default: idle_pct <= 60;
      endcase
    end
  end

  // Receiver: stall in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (!calm && $urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 6);
    m_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready) board.take_item(s_tuser, s_tdata, s_tlast);
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) board.check_verdict(m_tdata);
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("tb: timeout after %0d cycles", cycles);
    $display("tb: FAIL");
    $finish;
  end

  task automatic send(input logic [CmdW-1:0] cmd, input logic [3:0] from_state,
                      input logic [7:0] sym, input logic [3:0] to_state, input logic last);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {to_state, sym, from_state};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sweep_pending = (cmd == CmdClear);
    if (cmd != CmdNone) fed++;
  endtask

  task automatic send_char(input logic [7:0] sym, input logic last);
    send(CmdChar, 4'($urandom), sym, 4'($urandom), last);
  endtask

  task automatic send_add(input logic [3:0] from_state, input logic [7:0] sym,
                          input logic [3:0] to_state);
    send(CmdAdd, from_state, sym, to_state, 1'($urandom));
  endtask

  // Hold off until every verdict is in and the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_verdicts.size() != 0);
    repeat (sweep_pending ? SweepWait : DrainWait) @(posedge clk);
  endtask

  task automatic write_count(input logic [StateCountW-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(value);
    settings++;
  endtask

  initial begin
    int unsigned start;
    int unsigned n;
    int unsigned k;
    int unsigned len;
    int unsigned clears_left;
    logic [7:0]  alpha [4];
    logic [StateCountW-1:0] count_val;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = CmdClear;
    m_tready = 1'b0;
    calm = 0;
    idle_pct = 0;
    stall_left = 0;
    cycles = 0;
    fed = 0;
    settings = 0;
    sweep_pending = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: three states, state 2 accepts.
    settle();
    write_count(3);
    send(CmdClear, 4'hF, 8'hFF, 4'hF, 1'b1);
    send_add(0, "a", 1);
    send_add(0, "a", 0);
    send_add(1, "b", 2);
    send_add(2, "b", 4'd15);
    send_add(4'd15, 8'hFF, 4'd15);
    send_add(0, 8'h00, 2);
    send(CmdNone, 4'hF, 8'hFF, 4'hF, 1'b1);
    send_char("a", 0);
    send_char("b", 1);
    send_char(8'h00, 1);
    send_char("a", 1);
    // reject on the first character, rest of the word ignored
    send_char("c", 0);
    send_char("a", 0);
    send_char("b", 1);
    // target beyond the state count empties the set
    send_char("a", 0);
    send_char("b", 0);
    send_char("b", 1);
    send_char(8'hFF, 1);
    // clear in mid-word keeps the word going
    send_char("a", 0);
    send(CmdClear, 4'h0, 8'h00, 4'h0, 1'b0);
    send_char("b", 1);

    start = fed;
    clears_left = 6;
    while (fed - start < RandomItems) begin
      settle();
      case ($urandom_range(0, 7))
        0: count_val = 0;
        1: count_val = 1;
        2: count_val = 16;
        3: count_val = 31;
        4: count_val = 5'($urandom_range(17, 30));
        default: count_val = 5'($urandom_range(2, 15));
      endcase
      write_count(count_val);
      n = board.states_used();
      if (clears_left != 0 && $urandom_range(0, 2) == 0) begin
        send(CmdClear, 4'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
        clears_left--;
      end
      k = $urandom_range(2, 4);
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
      end
      // chain through every state so that some words reach the accepting one
      if (n == 1) send_add(0, alpha[$urandom_range(0, k-1)], 0);
      for (int i = 0; i + 1 < n; i++) send_add(4'(i), alpha[$urandom_range(0, k-1)], 4'(i+1));
      repeat ($urandom_range(2, 10)) begin
        send_add($urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, n-1)),
                 $urandom_range(0, 7) == 0 ? 8'($urandom) : alpha[$urandom_range(0, k-1)],
                 4'($urandom));
      end
      repeat ($urandom_range(4, 10)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 0)
              send(CmdNone, 4'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
            else
              send_add(4'($urandom), 8'($urandom), 4'($urandom));
          end
          send_char($urandom_range(0, 9) == 0 ? 8'($urandom) : alpha[$urandom_range(0, k-1)],
                    j == len - 1);
        end
      end
      if (fed - start > RandomItems - 150) calm = 1;
    end

    settle();
    if (board.pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", board.pending_verdicts.size());
      board.errors++;
    end
    $display("tb: %0d items fed under %0d state-count settings, random automata and words",
             fed, settings);
    $display("tb: %0d verdicts checked, %0d accepted, %0d errors",
             board.verdicts, board.accepts, board.errors);
    if (board.errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
